// ===== sv/rwwq_pkg.sv =====
// ----------------------------------------------------------------------------
// rwwq_pkg
// Shared types and codes for the reader/writer wait queue unit.
// ----------------------------------------------------------------------------
package rwwq_pkg;

	localparam int unsigned DEF_QUEUE_DEPTH = 16;
	localparam int unsigned DEF_ID_BITS     = 8;
	localparam int unsigned ID_PORT_W       = 8;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_REL_ALL = 2'd1,
		OP_REL_SEL = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_EMPTY,
		S_FETCH,
		S_EVAL
	} state_t;

	typedef struct packed {
		logic capture;
		logic walk_start;
		logic do_add;
		logic do_empty;
		logic fetch;
		logic eval;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic out_free;
		logic emit_needed;
		logic walk_end;
	} sts_t;

endpackage

// ===== sv/reader_writer_wait_queue_unit.sv =====
// ----------------------------------------------------------------------------
// reader_writer_wait_queue_unit
// Ordered queue of lock waiters with add, release-all and release-by-type.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_stall with operation, waiter_id and
// wants_write; results leave on res_valid/res_stall, one per released waiter
// or a single status result, with last_of_run on the final one of a request.
// The sequencer takes one request at a time: req_stall stays high until the
// current request is finished, its last result loaded into the result
// register and, for a release, the walk over the queue done.
// Add and release on an empty queue go to S_ADD or S_EMPTY, which loads the
// status result once the result register is free and then returns to idle.
// Release walks the circular entry memory with a fetch and an evaluate step
// per entry (single read port, registered read data): release-all walks all
// N waiters, the walk ends when the head writer is popped, and a reader
// release walks all N entries, writers being written back compacted.
// Operation code three is taken and dropped with no result.
// A stalled result holds in the result register; the walk waits only when a
// new result is due while it is still occupied.
// Reset empties the queue and clears the result register; entry contents are
// left as they are.
// ----------------------------------------------------------------------------
module reader_writer_wait_queue_unit
	import rwwq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int unsigned ID_BITS     = DEF_ID_BITS
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [1:0]           operation,
	input  logic [ID_PORT_W-1:0] waiter_id,
	input  logic                 wants_write,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [ID_PORT_W-1:0] released_id,
	output logic                 released_valid,
	output logic                 released_write,
	output logic [1:0]           status,
	output logic                 last_of_run
);

	cmd_t cmd;
	sts_t sts;

	rwwq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.operation (operation),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rwwq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.operation      (operation),
		.waiter_id      (waiter_id),
		.wants_write    (wants_write),
		.cmd            (cmd),
		.sts            (sts),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.released_id    (released_id),
		.released_valid (released_valid),
		.released_write (released_write),
		.status         (status),
		.last_of_run    (last_of_run)
	);

endmodule

// ===== sv/rwwq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rwwq_ctrl
// Sequencer for the wait queue: takes a request, then runs the add, the
// empty-release result or the fetch/evaluate walk over the queue.
// ----------------------------------------------------------------------------
module rwwq_ctrl
	import rwwq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] operation,
	output logic       req_stall,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_nx;
	op_t    op_in;

	assign op_in = op_t'(operation);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (op_in) inside
						OP_ADD:                 state_nx = S_ADD;
						OP_REL_ALL, OP_REL_SEL: state_nx = sts.cnt_zero ? S_EMPTY : S_FETCH;
						default:                state_nx = S_IDLE;
					endcase
				end
			end
			S_ADD: begin
				if (sts.out_free) state_nx = S_IDLE;
			end
			S_EMPTY: begin
				if (sts.out_free) state_nx = S_IDLE;
			end
			S_FETCH: state_nx = S_EVAL;
			S_EVAL: begin
				if (!sts.emit_needed || sts.out_free) begin
					state_nx = sts.walk_end ? S_IDLE : S_FETCH;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall      = 1'b0;
				cmd.capture    = req_valid;
				cmd.walk_start = req_valid && !sts.cnt_zero &&
				                 (op_in == OP_REL_ALL || op_in == OP_REL_SEL);
			end
			S_ADD:   cmd.do_add   = sts.out_free;
			S_EMPTY: cmd.do_empty = sts.out_free;
			S_FETCH: cmd.fetch    = 1'b1;
			S_EVAL:  cmd.eval     = !sts.emit_needed || sts.out_free;
			default: req_stall    = 1'b1;
		endcase
	end

endmodule

// ===== sv/rwwq_dp.sv =====
// ----------------------------------------------------------------------------
// rwwq_dp
// Datapath of the wait queue: circular entry memory, head/tail pointers,
// occupancy and reader counts, walk registers and the result register.
// ----------------------------------------------------------------------------
module rwwq_dp
	import rwwq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int unsigned ID_BITS     = DEF_ID_BITS
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           operation,
	input  logic [ID_PORT_W-1:0] waiter_id,
	input  logic                 wants_write,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [ID_PORT_W-1:0] released_id,
	output logic                 released_valid,
	output logic                 released_write,
	output logic [1:0]           status,
	output logic                 last_of_run
);

	localparam int unsigned STORE_W = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
	localparam int unsigned ENT_W   = STORE_W + 1;
	localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			ptr_inc = '0;
		end else begin
			ptr_inc = p + 1'b1;
		end
	endfunction

	logic [ENT_W-1:0]   mem_q [QUEUE_DEPTH];
	logic [ENT_W-1:0]   rd_data_q;
	logic               mem_we;
	logic [PTR_W-1:0]   mem_waddr;
	logic [ENT_W-1:0]   mem_wdata;

	op_t                op_q;
	logic [STORE_W-1:0] id_q;
	logic               wr_q;

	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   readers_q;

	logic [PTR_W-1:0]   rp_q;
	logic [PTR_W-1:0]   wp_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   kept_q;
	logic [CNT_W-1:0]   seen_q;

	logic               out_valid_q;
	logic [STORE_W-1:0] out_id_q;
	logic               out_rel_q;
	logic               out_wr_q;
	status_t            out_status_q;
	logic               out_last_q;

	logic               full;
	logic               out_free;
	logic               d_wr;
	logic [STORE_W-1:0] d_id;
	logic               first_ent;
	logic               last_ent;
	logic               pop;
	logic               emit;
	logic               walk_end;
	logic               keep;
	logic               emit_last;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign out_free  = !out_valid_q || !res_stall;
	assign d_wr      = rd_data_q[STORE_W];
	assign d_id      = rd_data_q[STORE_W-1:0];
	assign first_ent = (idx_q == CNT_W'(1));
	assign last_ent  = (idx_q == count_q);
	assign pop       = (op_q == OP_REL_SEL) && first_ent && d_wr;
	assign emit      = (op_q == OP_REL_ALL) || pop || !d_wr;
	assign walk_end  = pop || last_ent;
	assign keep      = !emit;

	always_comb begin
		if (op_q == OP_REL_ALL) begin
			emit_last = last_ent;
		end else if (pop) begin
			emit_last = 1'b1;
		end else begin
			emit_last = ((seen_q + CNT_W'(1)) == readers_q);
		end
	end

	assign sts.cnt_zero    = (count_q == '0);
	assign sts.out_free    = out_free;
	assign sts.emit_needed = emit;
	assign sts.walk_end    = walk_end;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = {wr_q, id_q};
		if (cmd.do_add && !full) begin
			mem_we = 1'b1;
		end else if (cmd.eval && keep) begin
			mem_we    = 1'b1;
			mem_waddr = wp_q;
			mem_wdata = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (cmd.fetch) rd_data_q <= mem_q[rp_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op_t'(operation);
			id_q <= waiter_id[STORE_W-1:0];
			wr_q <= wants_write;
		end
		if (cmd.walk_start) begin
			rp_q   <= head_q;
			wp_q   <= head_q;
			idx_q  <= '0;
			kept_q <= '0;
			seen_q <= '0;
		end else if (cmd.fetch) begin
			rp_q  <= ptr_inc(rp_q);
			idx_q <= idx_q + 1'b1;
		end else if (cmd.eval) begin
			if (keep) begin
				wp_q   <= ptr_inc(wp_q);
				kept_q <= kept_q + 1'b1;
			end else if (!d_wr) begin
				seen_q <= seen_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			readers_q <= '0;
		end else if (cmd.do_add && !full) begin
			tail_q  <= ptr_inc(tail_q);
			count_q <= count_q + 1'b1;
			if (!wr_q) readers_q <= readers_q + 1'b1;
		end else if (cmd.eval && walk_end) begin
			if (op_q == OP_REL_ALL) begin
				tail_q    <= head_q;
				count_q   <= '0;
				readers_q <= '0;
			end else if (pop) begin
				head_q  <= ptr_inc(head_q);
				count_q <= count_q - 1'b1;
			end else begin
				tail_q    <= keep ? ptr_inc(wp_q) : wp_q;
				count_q   <= keep ? kept_q + 1'b1 : kept_q;
				readers_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.do_add || cmd.do_empty || (cmd.eval && emit)) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_add || cmd.do_empty) begin
			out_id_q     <= '0;
			out_rel_q    <= 1'b0;
			out_wr_q     <= 1'b0;
			out_last_q   <= 1'b1;
			out_status_q <= cmd.do_empty ? ST_EMPTY : (full ? ST_FULL : ST_OK);
		end else if (cmd.eval && emit) begin
			out_id_q     <= d_id;
			out_rel_q    <= 1'b1;
			out_wr_q     <= d_wr;
			out_last_q   <= emit_last;
			out_status_q <= ST_OK;
		end
	end

	assign res_valid      = out_valid_q;
	assign released_id    = ID_PORT_W'(out_id_q);
	assign released_valid = out_rel_q;
	assign released_write = out_wr_q;
	assign status         = out_status_q;
	assign last_of_run    = out_last_q;

endmodule

// ===== tb/rwwq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rwwq_checker
// Watches both channels of the wait queue unit, keeps its own copy of the
// waiter list, predicts the results of each accepted request and compares
// every accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rwwq_checker
	import rwwq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  logic [1:0]           operation,
	input  logic [ID_PORT_W-1:0] waiter_id,
	input  logic                 wants_write,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  logic [ID_PORT_W-1:0] released_id,
	input  logic                 released_valid,
	input  logic                 released_write,
	input  logic [1:0]           status,
	input  logic                 last_of_run,
	output int                   mismatches,
	output int                   results_due,
	output int                   requests_seen,
	output int                   results_seen,
	output int                   waiters_released,
	output int                   full_drops,
	output int                   empty_releases
);

	localparam logic [ID_PORT_W-1:0] ID_MASK = ID_PORT_W'((64'd1 << DEF_ID_BITS) - 1);

	typedef struct packed {
		logic [ID_PORT_W-1:0] id;
		logic                 wr;
	} waiter_t;

	typedef struct packed {
		logic [ID_PORT_W-1:0] id;
		logic                 valid;
		logic                 wr;
		status_t              st;
		logic                 last;
	} outcome_t;

	waiter_t  waiters[$];
	outcome_t due_results[$];
	outcome_t got;
	outcome_t want;

	function automatic outcome_t outcome(logic [ID_PORT_W-1:0] id, logic valid, logic wr,
			status_t st);
		outcome_t o;
		o.id    = id;
		o.valid = valid;
		o.wr    = wr;
		o.st    = st;
		o.last  = 1'b0;
		return o;
	endfunction

	task automatic apply_request(op_t op, logic [ID_PORT_W-1:0] id, logic wr);
		waiter_t  kept[$];
		outcome_t batch[$];
		outcome_t tail;
		waiter_t  w;
		case (op) inside
			OP_ADD: begin
				if (waiters.size() >= DEF_QUEUE_DEPTH) begin
					batch.push_back(outcome('0, 1'b0, 1'b0, ST_FULL));
					full_drops++;
				end else begin
					w.id = id & ID_MASK;
					w.wr = wr;
					waiters.push_back(w);
					batch.push_back(outcome('0, 1'b0, 1'b0, ST_OK));
				end
			end
			OP_REL_ALL, OP_REL_SEL: begin
				if (waiters.size() == 0) begin
					batch.push_back(outcome('0, 1'b0, 1'b0, ST_EMPTY));
					empty_releases++;
				end else if (op == OP_REL_ALL) begin
					foreach (waiters[i])
						batch.push_back(outcome(waiters[i].id, 1'b1, waiters[i].wr, ST_OK));
					waiters.delete();
				end else if (waiters[0].wr) begin
					batch.push_back(outcome(waiters[0].id, 1'b1, 1'b1, ST_OK));
					void'(waiters.pop_front());
				end else begin
					foreach (waiters[i]) begin
						if (waiters[i].wr)
							kept.push_back(waiters[i]);
						else
							batch.push_back(outcome(waiters[i].id, 1'b1, 1'b0, ST_OK));
					end
					waiters = kept;
				end
			end
			default: ;
		endcase
		if (batch.size() > 0) begin
			tail = batch[batch.size() - 1];
			tail.last = 1'b1;
			batch[batch.size() - 1] = tail;
		end
		foreach (batch[i]) begin
			if (batch[i].valid)
				waiters_released++;
			due_results.push_back(batch[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiters.delete();
			due_results.delete();
			mismatches       <= 0;
			results_due      <= 0;
			requests_seen    <= 0;
			results_seen     <= 0;
			waiters_released = 0;
			full_drops       = 0;
			empty_releases   = 0;
		end else begin
			if (req_valid && !req_stall) begin
				requests_seen <= requests_seen + 1;
				apply_request(op_t'(operation), waiter_id, wants_write);
			end
			if (res_valid && !res_stall) begin
				results_seen <= results_seen + 1;
				got.id    = released_id;
				got.valid = released_valid;
				got.wr    = released_write;
				got.st    = status_t'(status);
				got.last  = last_of_run;
				if (due_results.size() == 0) begin
					if (mismatches < 100)
						$display("%0t: unexpected result id=%0h valid=%b write=%b status=%0d last=%b",
							$time, got.id, got.valid, got.wr, got.st, got.last);
					mismatches <= mismatches + 1;
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						if (mismatches < 100) begin
							$display("%0t: result mismatch expected id=%0h valid=%b write=%b status=%0d last=%b",
								$time, want.id, want.valid, want.wr, want.st, want.last);
							$display("%0t: result mismatch actual   id=%0h valid=%b write=%b status=%0d last=%b",
								$time, got.id, got.valid, got.wr, got.st, got.last);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			results_due <= due_results.size();
		end
	end

endmodule

// ===== tb/reader_writer_wait_queue_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reader_writer_wait_queue_unit_tb
// Drives add, release-all and release-by-type requests into the wait queue
// unit with random gaps and result stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module reader_writer_wait_queue_unit_tb
	import rwwq_pkg::*;
();

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	logic [1:0]           operation;
	logic [ID_PORT_W-1:0] waiter_id;
	logic                 wants_write;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [ID_PORT_W-1:0] released_id;
	logic                 released_valid;
	logic                 released_write;
	logic [1:0]           status;
	logic                 last_of_run;

	int mismatches;
	int results_due;
	int requests_seen;
	int results_seen;
	int waiters_released;
	int full_drops;
	int empty_releases;

	int send_idle_pct = 12;
	int recv_idle_pct = 61;

	reader_writer_wait_queue_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.operation      (operation),
		.waiter_id      (waiter_id),
		.wants_write    (wants_write),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.released_id    (released_id),
		.released_valid (released_valid),
		.released_write (released_write),
		.status         (status),
		.last_of_run    (last_of_run)
	);

	rwwq_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.operation        (operation),
		.waiter_id        (waiter_id),
		.wants_write      (wants_write),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.released_id      (released_id),
		.released_valid   (released_valid),
		.released_write   (released_write),
		.status           (status),
		.last_of_run      (last_of_run),
		.mismatches       (mismatches),
		.results_due      (results_due),
		.requests_seen    (requests_seen),
		.results_seen     (results_seen),
		.waiters_released (waiters_released),
		.full_drops       (full_drops),
		.empty_releases   (empty_releases)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	initial begin
		#5_000_000;
		$display("reader_writer_wait_queue_unit regression: fail");
		$finish;
	end

	task automatic push_request(op_t op, logic [ID_PORT_W-1:0] id, logic wr);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		operation   <= op;
		waiter_id   <= id;
		wants_write <= wr;
		do @(posedge clk); while (req_stall !== 1'b0);
	endtask

	// hold the sender off until every predicted result has come out
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	task automatic random_traffic(int target);
		int done;
		int pick;
		int burst;
		done = 0;
		while (done < target) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				burst = $urandom_range(20, 12);
				repeat (burst)
					push_request(OP_ADD, ID_PORT_W'($urandom_range(255)),
						1'($urandom_range(1)));
				done += burst;
			end else begin
				if (pick < 55)
					push_request(OP_ADD, ID_PORT_W'($urandom_range(255)),
						1'($urandom_range(1)));
				else if (pick < 67)
					push_request(OP_REL_ALL, ID_PORT_W'($urandom_range(255)),
						1'($urandom_range(1)));
				else if (pick < 95)
					push_request(OP_REL_SEL, ID_PORT_W'($urandom_range(255)),
						1'($urandom_range(1)));
				else
					push_request(OP_NONE, ID_PORT_W'($urandom_range(255)),
						1'($urandom_range(1)));
				if (pick < 95)
					done++;
			end
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		operation   <= OP_ADD;
		waiter_id   <= '0;
		wants_write <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_request(OP_REL_SEL, 8'h00, 1'b0);
		push_request(OP_REL_ALL, 8'hFF, 1'b1);
		push_request(OP_NONE, 8'hFF, 1'b1);
		push_request(OP_ADD, 8'h00, 1'b0);
		push_request(OP_ADD, 8'hFF, 1'b1);
		push_request(OP_ADD, 8'h55, 1'b0);
		push_request(OP_REL_SEL, 8'h00, 1'b0);
		push_request(OP_REL_SEL, 8'h00, 1'b0);
		for (int i = 0; i < DEF_QUEUE_DEPTH; i++)
			push_request(OP_ADD, 8'(i * 17), i[0]);
		push_request(OP_ADD, 8'hA5, 1'b1);
		push_request(OP_REL_ALL, 8'h00, 1'b0);

		random_traffic(140);
		hold_until_drained();

		send_idle_pct = 61;
		recv_idle_pct = 12;
		random_traffic(150);
		hold_until_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_traffic(150);
		hold_until_drained();
		repeat (40) @(posedge clk);

		$display("covered %0d requests and %0d results under three gap and stall mixes",
			requests_seen, results_seen);
		$display("%0d waiters released, %0d adds dropped on full, %0d releases on empty",
			waiters_released, full_drops, empty_releases);
		if (mismatches == 0 && results_due == 0)
			$display("reader_writer_wait_queue_unit regression: pass");
		else
			$display("reader_writer_wait_queue_unit regression: fail");
		$finish;
	end

endmodule
